### hw/rtl/generational_slot_pool_with_claims_assert.svh
// ----------------------------------------------------------------------------
// Slot pool assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_SLOT_POOL_WITH_CLAIMS_ASSERT_SVH
`define GENERATIONAL_SLOT_POOL_WITH_CLAIMS_ASSERT_SVH
`ifndef SYNTHESIS
`define GSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GSP_ASSERT(lbl, clk, rst_n, prop, msg)
`define GSP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/gspool_pkg.sv
// ----------------------------------------------------------------------------
// Slot pool package
// Word types, operation and status codes, scan chunk constants.
// ----------------------------------------------------------------------------
package gspool_pkg;

    localparam int CHUNK   = 16;
    localparam int CHUNK_W = 4;

    typedef enum logic [1:0] {
        OP_EMIT    = 2'd0,
        OP_CLAIM   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_TICK    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_STALE       = 3'd2,
        ST_TAKEN       = 3'd3,
        ST_UNCLAIMED   = 3'd4,
        ST_WRONG_OWNER = 3'd5
    } t_status;

    typedef struct packed {
        t_op         operation;
        logic [5:0]  slot_index;
        logic [31:0] handle_generation;
        logic [31:0] owner_id;
        logic [23:0] lifetime;
        logic [23:0] elapsed;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [5:0]  granted_slot;
        logic [31:0] granted_generation;
        logic [6:0]  live_count;
    } t_out_word;

    typedef struct packed {
        logic               hit;
        logic [CHUNK_W-1:0] pos;
    } t_find;

endpackage

### hw/rtl/gspool_find.sv
// ----------------------------------------------------------------------------
// Slot pool free finder
// Lowest free slot within one chunk of the live bitmap.
// ----------------------------------------------------------------------------
module gspool_find import gspool_pkg::*; (
    input  logic [CHUNK-1:0] i_busy,
    output t_find            o_find
);

    always_comb begin
        o_find = '0;
        for (int j = CHUNK - 1; j >= 0; j--) begin
            if (!i_busy[j]) begin
                o_find.hit = 1'b1;
                o_find.pos = CHUNK_W'(j);
            end
        end
    end

endmodule

### hw/rtl/generational_slot_pool_with_claims.sv
// ----------------------------------------------------------------------------
// Generational slot pool with claims
// Slot records live in one synchronous memory; live bits sit in flops.
// ----------------------------------------------------------------------------
// After reset the block clears the slot memory, one entry a cycle, before it
// takes its first word. Claim and release read the memory at the accepting
// edge; the check and write-back follow. Emit scans the live bitmap 16 slots a
// cycle for the lowest free slot and, if one is free, does one read-modify-write
// of that slot. A tick reads every slot through the memory's read port, one
// slot a cycle, and writes the live ones back through its write port. One word
// is in work at a time; the next word can be taken in the cycle after the
// result is loaded, at the earliest. A finished result sits in an output
// register while the next word is taken, and a word in work stalls while that
// register is still occupied.
module generational_slot_pool_with_claims import gspool_pkg::*; #(
    parameter int SLOTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

`include "generational_slot_pool_with_claims_assert.svh"

    localparam int IW     = $clog2(SLOTS);
    localparam int CW     = $clog2(SLOTS + 1);
    localparam int NCHUNK = (SLOTS + CHUNK - 1) / CHUNK;
    localparam int KW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PADW   = NCHUNK * CHUNK;
    localparam int XW     = (IW > 6) ? IW : 6;

    typedef struct packed {
        logic [31:0] gen;
        logic        claimed;
        logic [31:0] owner;
        logic [23:0] time_left;
    } t_slot_rec;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SEARCH = 7'b0000100,
        S_EMIT   = 7'b0001000,
        S_CHECK  = 7'b0010000,
        S_TICK   = 7'b0100000,
        S_TDONE  = 7'b1000000
    } t_state;

    t_slot_rec r_mem [SLOTS];
    t_slot_rec r_rd_data;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_walk, n_walk;
    logic [KW-1:0]   r_chunk, n_chunk;
    logic [SLOTS-1:0] r_live, n_live;
    logic [CW-1:0]   r_live_total, n_live_total;
    logic            r_out_valid, n_out_valid;
    t_out_word       r_out_word, n_out_word;
    logic            r_wb_valid, n_wb_valid;
    logic [IW-1:0]   r_wb_addr, n_wb_addr;
    t_in_word        r_req, n_req;
    logic            r_in_ok, n_in_ok;
    logic [IW-1:0]   r_found, n_found;
    logic            r_found_ok, n_found_ok;

    logic            w_accept;
    logic            w_fin;
    logic [XW-1:0]   w_in_x, w_req_x;
    logic [IW-1:0]   w_in_addr, w_req_addr;
    logic [PADW-1:0] w_live_pad;
    t_find           w_find;
    logic [IW-1:0]   w_found;
    logic            w_rd_en;
    logic [IW-1:0]   w_rd_addr;
    logic            w_we;
    logic [IW-1:0]   w_wr_addr;
    t_slot_rec       w_wr_data;
    logic [31:0]     w_next_gen;
    logic            w_handle_ok;
    logic [23:0]     w_time_next;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_fin       = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign w_in_x     = XW'(i_in_word.slot_index);
    assign w_in_addr  = w_in_x[IW-1:0];
    assign w_req_x    = XW'(r_req.slot_index);
    assign w_req_addr = w_req_x[IW-1:0];

    always_comb begin
        w_live_pad = '1;
        w_live_pad[SLOTS-1:0] = r_live;
    end

    gspool_find u_find (
        .i_busy (w_live_pad[r_chunk * CHUNK +: CHUNK]),
        .o_find (w_find)
    );

    assign w_found = IW'({r_chunk, w_find.pos});

    assign w_next_gen  = (r_rd_data.gen == 32'hFFFF_FFFF) ? 32'd1 : r_rd_data.gen + 32'd1;
    assign w_handle_ok = r_in_ok && (r_req.handle_generation != 32'd0)
                         && r_live[w_req_addr]
                         && (r_rd_data.gen == r_req.handle_generation);
    assign w_time_next = (r_rd_data.time_left > r_req.elapsed)
                         ? r_rd_data.time_left - r_req.elapsed : 24'd0;

    always_comb begin
        n_state      = r_state;
        n_walk       = r_walk;
        n_chunk      = r_chunk;
        n_live       = r_live;
        n_live_total = r_live_total;
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        n_wb_valid   = 1'b0;
        n_wb_addr    = r_wb_addr;
        n_req        = r_req;
        n_in_ok      = r_in_ok;
        n_found      = r_found;
        n_found_ok   = r_found_ok;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_walk;
        w_we         = 1'b0;
        w_wr_addr    = r_walk;
        w_wr_data    = r_rd_data;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // tick write-back stage
        if (r_wb_valid && r_live[r_wb_addr]) begin
            w_we                = 1'b1;
            w_wr_addr           = r_wb_addr;
            w_wr_data.time_left = w_time_next;
            if (w_time_next == 24'd0) begin
                w_wr_data.claimed  = 1'b0;
                w_wr_data.owner    = '0;
                n_live[r_wb_addr]  = 1'b0;
                n_live_total       = r_live_total - CW'(1);
            end
        end

        unique case (r_state)
            S_CLEAR: begin
                w_we      = 1'b1;
                w_wr_addr = r_walk;
                w_wr_data = '0;
                if (r_walk == IW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                    n_walk  = '0;
                end else begin
                    n_walk = r_walk + IW'(1);
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_req   = i_in_word;
                    n_in_ok = 32'(i_in_word.slot_index) < 32'(SLOTS);
                    unique case (i_in_word.operation)
                        OP_EMIT: begin
                            n_chunk = '0;
                            n_state = S_SEARCH;
                        end
                        OP_CLAIM, OP_RELEASE: begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = w_in_addr;
                            n_state   = S_CHECK;
                        end
                        OP_TICK: begin
                            n_walk  = '0;
                            n_state = S_TICK;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_find.hit) begin
                    w_rd_en    = 1'b1;
                    w_rd_addr  = w_found;
                    n_found    = w_found;
                    n_found_ok = 1'b1;
                    n_state    = S_EMIT;
                end else if (r_chunk == KW'(NCHUNK - 1)) begin
                    n_found_ok = 1'b0;
                    n_state    = S_EMIT;
                end else begin
                    n_chunk = r_chunk + KW'(1);
                end
            end
            S_EMIT: begin
                if (w_fin) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_found_ok) begin
                        w_we              = 1'b1;
                        w_wr_addr         = r_found;
                        w_wr_data.gen     = w_next_gen;
                        w_wr_data.claimed = 1'b0;
                        w_wr_data.owner   = '0;
                        w_wr_data.time_left = r_req.lifetime;
                        n_live[r_found]   = 1'b1;
                        n_live_total      = r_live_total + CW'(1);
                        n_out_word.status             = ST_OK;
                        n_out_word.granted_slot       = 6'(r_found);
                        n_out_word.granted_generation = w_next_gen;
                    end else begin
                        n_out_word.status             = ST_FULL;
                        n_out_word.granted_slot       = '0;
                        n_out_word.granted_generation = '0;
                    end
                    n_out_word.live_count = 7'(n_live_total);
                end
            end
            S_CHECK: begin
                if (w_fin) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_out_word.status             = ST_OK;
                    n_out_word.granted_slot       = r_req.slot_index;
                    n_out_word.granted_generation = '0;
                    n_out_word.live_count         = 7'(r_live_total);
                    w_wr_addr = w_req_addr;
                    priority if (!w_handle_ok) begin
                        n_out_word.status = ST_STALE;
                    end else if (r_req.operation == OP_CLAIM) begin
                        if (r_rd_data.claimed) begin
                            n_out_word.status = ST_TAKEN;
                        end else begin
                            w_we              = 1'b1;
                            w_wr_data.claimed = 1'b1;
                            w_wr_data.owner   = r_req.owner_id;
                        end
                    end else if (!r_rd_data.claimed) begin
                        n_out_word.status = ST_UNCLAIMED;
                    end else if (r_rd_data.owner != r_req.owner_id) begin
                        n_out_word.status = ST_WRONG_OWNER;
                    end else begin
                        w_we              = 1'b1;
                        w_wr_data.claimed = 1'b0;
                        w_wr_data.owner   = '0;
                    end
                end
            end
            S_TICK: begin
                w_rd_en    = 1'b1;
                w_rd_addr  = r_walk;
                n_wb_valid = 1'b1;
                n_wb_addr  = r_walk;
                if (r_walk == IW'(SLOTS - 1)) begin
                    n_walk  = '0;
                    n_state = S_TDONE;
                end else begin
                    n_walk = r_walk + IW'(1);
                end
            end
            S_TDONE: begin
                if (w_fin && !r_wb_valid) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_out_word.status             = ST_OK;
                    n_out_word.granted_slot       = r_req.slot_index;
                    n_out_word.granted_generation = '0;
                    n_out_word.live_count         = 7'(r_live_total);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_walk       <= '0;
            r_chunk      <= '0;
            r_live       <= '0;
            r_live_total <= '0;
            r_out_valid  <= 1'b0;
            r_wb_valid   <= 1'b0;
            r_found_ok   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_walk       <= n_walk;
            r_chunk      <= n_chunk;
            r_live       <= n_live;
            r_live_total <= n_live_total;
            r_out_valid  <= n_out_valid;
            r_wb_valid   <= n_wb_valid;
            r_found_ok   <= n_found_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_wb_addr  <= n_wb_addr;
        r_req      <= n_req;
        r_in_ok    <= n_in_ok;
        r_found    <= n_found;
    end

    `GSP_ASSERT(a_count_matches, i_clk, i_rst_n, r_live_total == CW'($countones(r_live)), "live count out of step with live bits")
    `GSP_ASSERT(a_wb_in_tick, i_clk, i_rst_n, r_wb_valid |-> (r_state == S_TICK || r_state == S_TDONE), "tick write-back outside tick")
    `GSP_ASSERT(a_out_hold_busy, i_clk, i_rst_n, (r_state == S_TDONE && r_wb_valid) |=> !$rose(o_out_valid) || !$past(r_wb_valid), "tick result before last write-back")
    `GSP_ASSERT_ALWAYS(a_clear_after_reset, i_clk, $past(!i_rst_n) |-> !o_in_ready, "ready during memory clear")

endmodule

### tb/generational_slot_pool_with_claims_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Generational slot pool testbench
// Drives emit, claim, release and tick words through the valid/ready input,
// mirrors the pool's slots, generations, claims and lifetimes in a local
// model, and checks every result word field by field under random stalls.
// ----------------------------------------------------------------------------
module generational_slot_pool_with_claims_tb;
    import gspool_pkg::*;

    localparam int SLOTS      = 64;
    localparam int WORD_GOAL  = 1320;
    localparam int CALM_FROM  = 6000;
    localparam int CALM_TO    = 10000;
    localparam int HOLD_AT    = 2500;
    localparam int HOLD_LEN   = 400;
    localparam int TAIL       = 80;
    localparam int STUCK_MAX  = 3000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_ready = 1'b0;
    t_in_word  in_word = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    logic [31:0] pool_gen [SLOTS];
    logic        pool_live [SLOTS];
    logic        pool_claimed [SLOTS];
    logic [31:0] pool_owner [SLOTS];
    logic [23:0] pool_left [SLOTS];
    logic [6:0]  pool_count;

    t_in_word  req_words [$];
    t_out_word req_replies [$];
    t_out_word owed_replies [$];
    t_out_word held_reply;
    int        words_made = 0;
    int        replies_seen = 0;
    int        fail_count = 0;
    int        tx_cycles = 0;
    int        rx_cycles = 0;
    int        hold_left = 0;
    int        stuck_cycles = 0;

    generational_slot_pool_with_claims #(.SLOTS(SLOTS)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word)
    );

    always #6 i_clk = ~i_clk;

    function automatic bit handle_matches(logic [5:0] idx, logic [31:0] gen);
        return gen != 32'd0 && pool_live[idx] && pool_gen[idx] == gen;
    endfunction

    function automatic t_out_word pool_step(t_in_word w);
        t_out_word   r;
        logic [31:0] g;
        bit          found;
        r.status = ST_OK;
        r.granted_slot = w.slot_index;
        r.granted_generation = '0;
        found = 1'b0;
        case (w.operation)
            OP_EMIT: begin
                r.status = ST_FULL;
                r.granted_slot = '0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!found && !pool_live[i]) begin
                        found = 1'b1;
                        g = pool_gen[i] + 32'd1;
                        if (g == 32'd0) g = 32'd1;
                        pool_gen[i] = g;
                        pool_left[i] = w.lifetime;
                        pool_live[i] = 1'b1;
                        pool_claimed[i] = 1'b0;
                        pool_owner[i] = '0;
                        pool_count++;
                        r.status = ST_OK;
                        r.granted_slot = 6'(i);
                        r.granted_generation = g;
                    end
                end
            end
            OP_CLAIM: begin
                if (!handle_matches(w.slot_index, w.handle_generation)) begin
                    r.status = ST_STALE;
                end else if (pool_claimed[w.slot_index]) begin
                    r.status = ST_TAKEN;
                end else begin
                    pool_claimed[w.slot_index] = 1'b1;
                    pool_owner[w.slot_index] = w.owner_id;
                end
            end
            OP_RELEASE: begin
                if (!handle_matches(w.slot_index, w.handle_generation)) begin
                    r.status = ST_STALE;
                end else if (!pool_claimed[w.slot_index]) begin
                    r.status = ST_UNCLAIMED;
                end else if (pool_owner[w.slot_index] != w.owner_id) begin
                    r.status = ST_WRONG_OWNER;
                end else begin
                    pool_claimed[w.slot_index] = 1'b0;
                    pool_owner[w.slot_index] = '0;
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (pool_live[i]) begin
                        if (pool_left[i] > w.elapsed) pool_left[i] -= w.elapsed;
                        else pool_left[i] = '0;
                        if (pool_left[i] == '0) begin
                            pool_live[i] = 1'b0;
                            pool_claimed[i] = 1'b0;
                            pool_owner[i] = '0;
                            pool_count--;
                        end
                    end
                end
            end
        endcase
        r.live_count = pool_count;
        return r;
    endfunction

    function automatic t_in_word noise_word();
        t_in_word w;
        w.operation = t_op'($urandom_range(0, 3));
        w.slot_index = 6'($urandom_range(0, 63));
        w.handle_generation = $urandom;
        w.owner_id = $urandom;
        w.lifetime = 24'($urandom);
        w.elapsed = 24'($urandom);
        return w;
    endfunction

    function automatic logic [31:0] pick_owner();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 32'($urandom_range(0, 3));
    endfunction

    task automatic queue_request(t_in_word w);
        req_words.push_back(w);
        req_replies.push_back(pool_step(w));
        words_made++;
    endtask

    task automatic put(t_op op, logic [5:0] idx, logic [31:0] gen, logic [31:0] owner,
                       logic [23:0] life, logic [23:0] dt);
        t_in_word w;
        w.operation = op;
        w.slot_index = idx;
        w.handle_generation = gen;
        w.owner_id = owner;
        w.lifetime = life;
        w.elapsed = dt;
        queue_request(w);
    endtask

    // driver
    always @(posedge i_clk) begin : tx_proc
        bit busy;
        tx_cycles++;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            busy = in_valid;
            if (in_valid && o_in_ready) begin
                owed_replies.push_back(held_reply);
                busy = 1'b0;
            end
            if (!busy) begin
                if (req_words.size() != 0 &&
                    ((tx_cycles >= CALM_FROM && tx_cycles < CALM_TO) ||
                     $urandom_range(0, 99) >= 24)) begin
                    in_word <= req_words.pop_front();
                    held_reply = req_replies.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : rx_proc
        t_out_word want;
        rx_cycles++;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (owed_replies.size() == 0) begin
                    $display("%0t: result word %h arrived with none outstanding",
                             $time, o_out_word);
                    fail_count++;
                end else begin
                    want = owed_replies.pop_front();
                    replies_seen++;
                    if (o_out_word.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_out_word.status);
                        fail_count++;
                    end
                    if (o_out_word.granted_slot !== want.granted_slot) begin
                        $display("%0t: granted_slot expected %0d actual %0d",
                                 $time, want.granted_slot, o_out_word.granted_slot);
                        fail_count++;
                    end
                    if (o_out_word.granted_generation !== want.granted_generation) begin
                        $display("%0t: granted_generation expected %h actual %h",
                                 $time, want.granted_generation,
                                 o_out_word.granted_generation);
                        fail_count++;
                    end
                    if (o_out_word.live_count !== want.live_count) begin
                        $display("%0t: live_count expected %0d actual %0d",
                                 $time, want.live_count, o_out_word.live_count);
                        fail_count++;
                    end
                end
            end
            if (rx_cycles == HOLD_AT) hold_left = HOLD_LEN;
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= (rx_cycles >= CALM_FROM && rx_cycles < CALM_TO) ||
                             ($urandom_range(0, 99) >= 24);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_MAX) begin
            $display("%0t: no word moved for %0d cycles", $time, stuck_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_in_word w;
        int       live_list [$];
        int       pick;
        int       mode;
        int       k;

        for (int i = 0; i < SLOTS; i++) begin
            pool_gen[i] = '0;
            pool_live[i] = 1'b0;
            pool_claimed[i] = 1'b0;
            pool_owner[i] = '0;
            pool_left[i] = '0;
        end
        pool_count = '0;

        put(OP_TICK,    6'd0,  32'd0, 32'd0,        24'd0,        24'd0);
        put(OP_CLAIM,   6'd0,  32'd0, 32'd1,        24'd0,        24'd0);
        put(OP_EMIT,    6'd0,  32'd0, 32'd0,        24'd0,        24'd0);
        put(OP_EMIT,    6'd63, 32'd0, 32'd0,        24'hFFFFFF,   24'd0);
        put(OP_EMIT,    6'd0,  32'd0, 32'd0,        24'h000100,   24'd0);
        put(OP_CLAIM,   6'd1,  32'd1, 32'hFFFFFFFF, 24'd0,        24'd0);
        put(OP_CLAIM,   6'd1,  32'd1, 32'hFFFFFFFF, 24'd0,        24'd0);
        put(OP_CLAIM,   6'd1,  32'd2, 32'd1,        24'd0,        24'd0);
        put(OP_CLAIM,   6'd63, 32'd1, 32'd1,        24'd0,        24'd0);
        put(OP_RELEASE, 6'd2,  32'd1, 32'd5,        24'd0,        24'd0);
        put(OP_RELEASE, 6'd1,  32'd1, 32'd0,        24'd0,        24'd0);
        put(OP_RELEASE, 6'd1,  32'd1, 32'hFFFFFFFF, 24'd0,        24'd0);
        put(OP_CLAIM,   6'd2,  32'd1, 32'd0,        24'd0,        24'd0);
        put(OP_RELEASE, 6'd2,  32'd1, 32'd0,        24'd0,        24'd0);
        put(OP_CLAIM,   6'd2,  32'd1, 32'h12345678, 24'd0,        24'd0);
        put(OP_TICK,    6'd5,  32'd0, 32'd0,        24'd0,        24'd0);
        put(OP_EMIT,    6'd0,  32'd0, 32'd0,        24'h000010,   24'd0);
        put(OP_TICK,    6'd63, 32'd0, 32'd0,        24'd0,        24'hFFFFFF);
        put(OP_CLAIM,   6'd2,  32'd1, 32'h12345678, 24'd0,        24'd0);
        put(OP_EMIT,    6'd0,  32'd0, 32'd0,        24'hFFFFFF,   24'd0);
        put(OP_RELEASE, 6'd0,  32'd3, 32'd0,        24'd0,        24'd0);

        while (words_made < WORD_GOAL) begin
            // fill the pool now and then so emits run into a full pool
            if (words_made % 250 == 100) begin
                for (k = 0; k < 70; k++) begin
                    w = noise_word();
                    w.operation = OP_EMIT;
                    w.lifetime = 24'($urandom_range(24'h4000, 24'hFFFFFF));
                    queue_request(w);
                end
            end
            live_list.delete();
            for (int i = 0; i < SLOTS; i++)
                if (pool_live[i]) live_list.push_back(i);
            w = noise_word();
            mode = $urandom_range(0, 99);
            pick = live_list.size() != 0 ?
                   live_list[$urandom_range(0, live_list.size() - 1)] : 0;
            if (mode < 30) begin
                w.operation = OP_EMIT;
                k = $urandom_range(0, 9);
                if (k == 0) w.lifetime = '0;
                else if (k == 1) w.lifetime = 24'($urandom);
                else w.lifetime = 24'($urandom_range(1, 24'h2000));
            end else if (mode < 80) begin
                w.operation = mode < 55 ? OP_CLAIM : OP_RELEASE;
                if (live_list.size() != 0 && $urandom_range(0, 4) != 0) begin
                    w.slot_index = 6'(pick);
                    w.handle_generation = pool_gen[pick];
                    if (w.operation == OP_RELEASE && pool_claimed[pick] &&
                        $urandom_range(0, 9) < 6)
                        w.owner_id = pool_owner[pick];
                    else
                        w.owner_id = pick_owner();
                end else begin
                    k = $urandom_range(0, 2);
                    if (k == 0) begin
                        w.slot_index = 6'(pick);
                        w.handle_generation = '0;
                    end else if (k == 1) begin
                        w.slot_index = 6'(pick);
                        w.handle_generation = pool_gen[pick] + 32'd1;
                    end
                    w.owner_id = pick_owner();
                end
            end else begin
                w.operation = OP_TICK;
                k = $urandom_range(0, 9);
                if (k < 2) w.elapsed = '0;
                else if (k == 2) w.elapsed = 24'($urandom);
                else w.elapsed = 24'($urandom_range(1, 24'h0600));
            end
            queue_request(w);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (replies_seen < words_made) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (fail_count == 0 && owed_replies.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
